// ----- rtl/fici_pkg.sv -----
// fici_pkg: shared types, codes and constants for the fixel index cover check
// no dependencies; used by fici_step_unit, the core and the bench
`timescale 1ns / 1ps

package fici_pkg;

    // default cover store depth
    localparam int MAX_FIXELS_DEF = 65536;

    // width of the shared add / compare unit operands
    localparam int OPW = 33;

    // stream payload widths
    localparam int COUNT_W     = 16;
    localparam int OFFSET_W    = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // input kind carried on tuser
    localparam logic ACT_ENTRY  = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // configuration register indexes
    localparam logic CFG_HDR_TOTAL = 1'b0;
    localparam logic CFG_HDR_GIVEN = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_CAPACITY = 2'd2;
    localparam logic [1:0] STAT_COVER    = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ADD,
        S_CHECK,
        S_WALK,
        S_SCAN,
        S_DONE
    } t_state;

    // shared unit result
    typedef struct packed {
        logic [OPW-1:0] sum;
        logic           lt;
    } t_unit_res;

    // two-bit cover counter, saturating at three
    function automatic logic [1:0] sat_inc(input logic [1:0] v);
        logic [1:0] r;
        r = (v == 2'd3) ? 2'd3 : v + 2'd1;
        return r;
    endfunction

endpackage

// ----- rtl/fici_cover_ram.sv -----
// fici_cover_ram: cover counter store, one write and one registered read per cycle
// depends on nothing but its parameters
`timescale 1ns / 1ps

module fici_cover_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fici_step_unit.sv -----
// fici_step_unit: shared 33-bit adder with a less-than compare
// depends on fici_pkg for the operand width and result struct
`timescale 1ns / 1ps

module fici_step_unit (
    input  logic [fici_pkg::OPW-1:0] i_a,
    input  logic [fici_pkg::OPW-1:0] i_b,
    input  logic [fici_pkg::OPW-1:0] i_c,
    output fici_pkg::t_unit_res      o_res
);

    // sum for end and index stepping, compare against the walk limit
    always_comb begin
        o_res.sum = i_a + i_b;
        o_res.lt  = (i_a < i_c);
    end

endmodule

// ----- rtl/fixel_index_cover_check_core.sv -----
// fixel_index_cover_check_core: top level of the fixel index cover check, on fici_pkg,
//   fici_step_unit and fici_cover_ram; one shared adder walks the store a word a cycle
// entry: add forms the end, check clips it, then the walk reads each fixel in the store
//   and writes it back bumped; empty entries are dropped, a wrapped end stops at check
// finish: scans min(total, MAX_FIXELS) entries, then loads the result register
// reset: synchronous active low, then a clearing pass over every entry of the store
`timescale 1ns / 1ps

module fixel_index_cover_check_core #(
    parameter int MAX_FIXELS = fici_pkg::MAX_FIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] fixel_count, [47:16] first_offset
    input  logic [fici_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] action
    input  logic                                i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] status, [33:2] total_fixels, [49:34] bad_index,
    // [51:50] bad_cover, [52] header_mismatch, [55:53] zero
    output logic [fici_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [31:0]                         i_cfg_data
);

    localparam int AW = $clog2(MAX_FIXELS);
    localparam logic [AW:0] LIM_MAX = (AW+1)'(MAX_FIXELS);
    localparam logic [fici_pkg::OPW-1:0] MAX_EXT = fici_pkg::OPW'(MAX_FIXELS);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    fici_pkg::t_state r_state, n_state;

    logic [AW:0]     r_idx, n_idx;          // walk index, can reach the depth
    logic [AW:0]     r_lim, n_lim;          // walk end, exclusive
    logic [AW-1:0]   r_wr_addr, n_wr_addr;  // address of the read in flight
    logic            r_rd_pend, n_rd_pend;  // read data lands this cycle

    logic [15:0]     r_cnt, n_cnt;
    logic [31:0]     r_off, n_off;
    logic [32:0]     r_end, n_end;

    logic [31:0]     r_total, n_total;
    logic            r_ovf, n_ovf;
    logic            r_cap, n_cap;

    logic            r_found, n_found;
    logic [AW-1:0]   r_bad_idx, n_bad_idx;
    logic [1:0]      r_bad_cov, n_bad_cov;

    logic [31:0]     r_hdr_total;
    logic            r_hdr_given;

    logic                             r_out_valid, n_out_valid;
    logic [fici_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // ------------------------------------------------------------------
    // shared add / compare unit
    // ------------------------------------------------------------------
    logic [fici_pkg::OPW-1:0] w_op_a, w_op_b, w_op_c;
    fici_pkg::t_unit_res      w_unit;

    // the entry end is formed in the add state, everything else steps the index
    always_comb begin
        if (r_state == fici_pkg::S_ADD) begin
            w_op_a = fici_pkg::OPW'(r_off);
            w_op_b = fici_pkg::OPW'(r_cnt);
        end else begin
            w_op_a = fici_pkg::OPW'(r_idx);
            w_op_b = fici_pkg::OPW'(1);
        end
        w_op_c = fici_pkg::OPW'(r_lim);
    end

    fici_step_unit u_step (
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .i_c   (w_op_c),
        .o_res (w_unit)
    );

    // ------------------------------------------------------------------
    // cover store
    // ------------------------------------------------------------------
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [1:0]    w_wdata, w_rdata;

    fici_cover_ram #(
        .DEPTH (MAX_FIXELS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    logic        w_in_acc;
    logic [15:0] w_in_cnt;
    logic [31:0] w_in_off;

    assign o_s_axis_tready = (r_state == fici_pkg::S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_cnt        = i_s_axis_tdata[15:0];
    assign w_in_off        = i_s_axis_tdata[47:16];

    // scan limit clipped to the store depth
    logic [AW:0] w_total_clip;
    assign w_total_clip = (fici_pkg::OPW'(r_total) > MAX_EXT) ? LIM_MAX : r_total[AW:0];

    // result fields
    logic        w_scan_en;
    logic [1:0]  w_status;
    logic [31:0] w_bad_ext;
    logic        w_mismatch;

    assign w_scan_en  = !r_ovf && !r_cap;
    assign w_status   = r_ovf   ? fici_pkg::STAT_OVERFLOW :
                        r_cap   ? fici_pkg::STAT_CAPACITY :
                        r_found ? fici_pkg::STAT_COVER    : fici_pkg::STAT_OK;
    assign w_bad_ext  = 32'(r_bad_idx);
    assign w_mismatch = r_hdr_given && (r_hdr_total != r_total);

    // ------------------------------------------------------------------
    // sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_wr_addr   = r_wr_addr;
        n_rd_pend   = r_rd_pend;
        n_cnt       = r_cnt;
        n_off       = r_off;
        n_end       = r_end;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_cap       = r_cap;
        n_found     = r_found;
        n_bad_idx   = r_bad_idx;
        n_bad_cov   = r_bad_cov;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;

        w_we    = 1'b0;
        w_waddr = r_wr_addr;
        w_wdata = 2'd0;
        w_re    = 1'b0;
        w_raddr = r_idx[AW-1:0];

        case (r_state)
            fici_pkg::S_INIT: begin
                // clearing pass after reset, one entry a cycle
                if (w_unit.lt) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[AW-1:0];
                    n_idx   = w_unit.sum[AW:0];
                end else begin
                    n_state = fici_pkg::S_IDLE;
                end
            end
            fici_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_axis_tuser == fici_pkg::ACT_FINISH) begin
                        n_idx     = '0;
                        n_lim     = w_total_clip;
                        n_rd_pend = 1'b0;
                        n_found   = 1'b0;
                        n_bad_idx = '0;
                        n_bad_cov = 2'd0;
                        n_state   = fici_pkg::S_SCAN;
                    end else if (w_in_cnt != 16'd0) begin
                        n_cnt   = w_in_cnt;
                        n_off   = w_in_off;
                        n_state = fici_pkg::S_ADD;
                    end
                end
            end
            fici_pkg::S_ADD: begin
                n_end   = w_unit.sum;
                n_state = fici_pkg::S_CHECK;
            end
            fici_pkg::S_CHECK: begin
                if (r_end[32]) begin
                    // end does not fit 32 bits: entry leaves total and store alone
                    n_ovf   = 1'b1;
                    n_state = fici_pkg::S_IDLE;
                end else begin
                    if (r_end[31:0] > r_total) begin
                        n_total = r_end[31:0];
                    end
                    if (r_end > MAX_EXT) begin
                        n_cap = 1'b1;
                        n_lim = LIM_MAX;
                    end else begin
                        n_lim = r_end[AW:0];
                    end
                    // an offset at or past the depth walks nothing
                    n_idx     = (fici_pkg::OPW'(r_off) >= MAX_EXT) ? LIM_MAX : r_off[AW:0];
                    n_rd_pend = 1'b0;
                    n_state   = fici_pkg::S_WALK;
                end
            end
            fici_pkg::S_WALK: begin
                // read one index while bumping the one read last cycle
                if (w_unit.lt) begin
                    w_re      = 1'b1;
                    n_idx     = w_unit.sum[AW:0];
                    n_wr_addr = r_idx[AW-1:0];
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                end
                if (r_rd_pend) begin
                    w_we    = 1'b1;
                    w_wdata = fici_pkg::sat_inc(w_rdata);
                end
                if (!w_unit.lt && !r_rd_pend) begin
                    n_state = fici_pkg::S_IDLE;
                end
            end
            fici_pkg::S_SCAN: begin
                // check each index below the total and clear it behind the read
                if (w_unit.lt) begin
                    w_re      = 1'b1;
                    n_idx     = w_unit.sum[AW:0];
                    n_wr_addr = r_idx[AW-1:0];
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                end
                if (r_rd_pend) begin
                    w_we = 1'b1;
                    if (w_scan_en && !r_found && (w_rdata != 2'd1)) begin
                        n_found   = 1'b1;
                        n_bad_idx = r_wr_addr;
                        n_bad_cov = w_rdata;
                    end
                end
                if (!w_unit.lt && !r_rd_pend) begin
                    n_state = fici_pkg::S_DONE;
                end
            end
            fici_pkg::S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'd0, w_mismatch, r_bad_cov, w_bad_ext[15:0],
                                   r_total, w_status};
                    n_total     = '0;
                    n_ovf       = 1'b0;
                    n_cap       = 1'b0;
                    n_state     = fici_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fici_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fici_pkg::S_INIT;
            r_idx       <= '0;
            r_lim       <= LIM_MAX;
            r_rd_pend   <= 1'b0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_cap       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_lim       <= n_lim;
            r_rd_pend   <= n_rd_pend;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_cap       <= n_cap;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_cnt      <= n_cnt;
        r_off      <= n_off;
        r_end      <= n_end;
        r_bad_idx  <= n_bad_idx;
        r_bad_cov  <= n_bad_cov;
        r_out_data <= n_out_data;
    end

    // configuration registers, kept across a finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_total <= '0;
            r_hdr_given <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fici_pkg::CFG_HDR_TOTAL: r_hdr_total <= i_cfg_data;
                fici_pkg::CFG_HDR_GIVEN: r_hdr_given <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // the store never sees a write and a read of the same entry in one cycle
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("cover store read and write collide");

    // walk index stays within its limit
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == fici_pkg::S_WALK) || (r_state == fici_pkg::S_SCAN)) |-> (r_idx <= r_lim))
        else $error("walk index passed its limit");

    // a result beat only appears after a finished scan
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == fici_pkg::S_DONE))
        else $error("result raised outside the done state");

    // no new beat is taken while the sequencer is busy
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == fici_pkg::S_WALK) || (r_state == fici_pkg::S_SCAN)) |=>
        (r_state != fici_pkg::S_ADD))
        else $error("entry accepted during a store walk");
`endif

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for fixel_index_cover_check_core, streams voxel entries and finish
// beats and checks every report against an in-bench cover tracker
// depends on fici_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;

    localparam int unsigned STORE_DEPTH = fici_pkg::MAX_FIXELS_DEF;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned BEAT_TARGET = 650;

    // one report as it leaves the block, fields in tdata order
    typedef struct packed {
        logic       mismatch;
        logic [1:0] bad_cover;
        logic [15:0] bad_index;
        logic [31:0] total;
        logic [1:0] status;
    } t_fici_report;

    // one voxel entry of a generated image
    typedef struct {
        logic [15:0] cnt;
        logic [31:0] off;
    } t_entry;

    // shapes of generated images
    typedef enum {
        IMG_TILED,   // exact cover of [0, n)
        IMG_GAP,     // one tile dropped
        IMG_DUP,     // one tile repeated, cover two or saturated
        IMG_WRAP,    // tiling plus an entry whose end wraps 32 bits
        IMG_NOISE,   // random entries, mostly broken cover
        IMG_WIDE     // tiling plus an entry ending past the store
    } t_img_kind;

    // tracks cover counters, total and flags of the current image and
    // keeps the reports that the block still owes
    class t_cover_tracker;
        logic [1:0]   cover_cnt [STORE_DEPTH];
        logic [31:0]  total;
        bit           ovf_seen;
        bit           cap_seen;
        logic [31:0]  hdr_total;
        bit           hdr_given;
        t_fici_report reports_due[$];
        int unsigned  errors;

        function new();
            foreach (cover_cnt[i]) cover_cnt[i] = 2'd0;
            total     = '0;
            ovf_seen  = 0;
            cap_seen  = 0;
            hdr_total = '0;
            hdr_given = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] val);
            if (idx == fici_pkg::CFG_HDR_TOTAL) begin
                hdr_total = val;
            end else begin
                hdr_given = val[0];
            end
        endfunction

        // accepted input beat: update the image or close it with a report
        function void take_beat(logic act, logic [15:0] cnt, logic [31:0] off);
            t_fici_report r;
            logic [32:0]  last_end;
            logic [32:0]  idx;
            int unsigned  span;
            if (act == fici_pkg::ACT_ENTRY) begin
                if (cnt == 16'd0) return;
                last_end = {1'b0, off} + {17'd0, cnt};
                // wrapped end: only the flag, no total and no cover
                if (last_end[32]) begin
                    ovf_seen = 1;
                    return;
                end
                if (last_end[31:0] > total) total = last_end[31:0];
                if (last_end > STORE_DEPTH) cap_seen = 1;
                for (int j = 0; j < int'(cnt); j++) begin
                    idx = {1'b0, off} + j;
                    if (idx < STORE_DEPTH && cover_cnt[idx[15:0]] != 2'd3)
                        cover_cnt[idx[15:0]] = cover_cnt[idx[15:0]] + 2'd1;
                end
                return;
            end
            r       = '0;
            r.total = total;
            // overflow wins over capacity, cover scan only when both clear
            if (ovf_seen) begin
                r.status = fici_pkg::STAT_OVERFLOW;
            end else if (cap_seen) begin
                r.status = fici_pkg::STAT_CAPACITY;
            end else begin
                for (int unsigned i = 0; i < total && i < STORE_DEPTH; i++) begin
                    if (cover_cnt[i] != 2'd1) begin
                        r.status    = fici_pkg::STAT_COVER;
                        r.bad_index = i[15:0];
                        r.bad_cover = cover_cnt[i];
                        break;
                    end
                end
            end
            r.mismatch = hdr_given && (hdr_total != total);
            reports_due = {reports_due, r};
            // every touched counter lies below the total
            span = (total > STORE_DEPTH) ? STORE_DEPTH : total;
            for (int unsigned i = 0; i < span; i++) cover_cnt[i] = 2'd0;
            total    = '0;
            ovf_seen = 0;
            cap_seen = 0;
        endfunction

        function void note_error(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("report mismatch on %s: expected %0h, got %0h", field, want, got);
        endfunction

        // accepted output beat: compare with the oldest owed report
        function void check_report(logic [fici_pkg::OUT_TDATA_W-1:0] d);
            t_fici_report got;
            t_fici_report want;
            got = d[52:0];
            if (reports_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("report beat with none owed: %h", d);
                return;
            end
            want = reports_due.pop_front();
            if (got.status != want.status)
                note_error("status", 32'(want.status), 32'(got.status));
            if (got.total != want.total) note_error("total_fixels", want.total, got.total);
            if (got.bad_index != want.bad_index)
                note_error("bad_index", 32'(want.bad_index), 32'(got.bad_index));
            if (got.bad_cover != want.bad_cover)
                note_error("bad_cover", 32'(want.bad_cover), 32'(got.bad_cover));
            if (got.mismatch != want.mismatch)
                note_error("header_mismatch", 32'(want.mismatch), 32'(got.mismatch));
        endfunction
    endclass

    logic                                clk      = 1'b0;
    logic                                rst_n    = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic [fici_pkg::IN_TDATA_W-1:0]     s_tdata  = '0;
    logic                                s_tuser  = 1'b0;
    logic                                m_tready = 1'b0;
    logic                                cfg_we   = 1'b0;
    logic                                cfg_idx  = 1'b0;
    logic [31:0]                         cfg_data = '0;
    wire                                 s_tready;
    wire                                 m_tvalid;
    wire [fici_pkg::OUT_TDATA_W-1:0]     m_tdata;

    t_cover_tracker cover_tracker = new();

    bit          calm        = 0;   // no idling on either side while set
    int unsigned beats_sent  = 0;   // every accepted input beat
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned wide_images = 0;

    fixel_index_cover_check_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // [15:0] fixel_count, [47:16] first_offset
        .i_s_axis_tdata  (s_tdata),
        // [0] action
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // [1:0] status, [33:2] total_fixels, [49:34] bad_index,
        // [51:50] bad_cover, [52] header_mismatch
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop, far beyond the slowest correct run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fixel_index_cover_check_core regression: fail");
            $finish;
        end
    end

    // report side: check accepted beats, then pick next cycle's tready
    always @(posedge clk) begin
        if (rst_n && m_tvalid === 1'b1 && m_tready) cover_tracker.check_report(m_tdata);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            // start a stall burst with tready low
            stall_left = $urandom_range(1, 16) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one input beat; tvalid stays high afterwards so back-to-back beats
    // never lower and raise it in the same step
    task automatic send_beat(input logic act, input logic [15:0] cnt, input logic [31:0] off);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {off, cnt};
        do @(posedge clk); while (s_tready !== 1'b1);
        cover_tracker.take_beat(act, cnt, off);
        beats_sent++;
    endtask

    // sender holds off until every owed report is in, then a short settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cover_tracker.reports_due.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // both header registers, one write per edge, only while idle
    task automatic set_header(input logic [31:0] hdr_total, input logic hdr_given);
        cfg_we   <= 1'b1;
        cfg_idx  <= fici_pkg::CFG_HDR_TOTAL;
        cfg_data <= hdr_total;
        @(posedge clk);
        cover_tracker.write_reg(fici_pkg::CFG_HDR_TOTAL, hdr_total);
        cfg_idx  <= fici_pkg::CFG_HDR_GIVEN;
        cfg_data <= {31'd0, hdr_given};
        @(posedge clk);
        cover_tracker.write_reg(fici_pkg::CFG_HDR_GIVEN, {31'd0, hdr_given});
        cfg_we   <= 1'b0;
    endtask

    // build one image around a tiling of [0, n), shuffle, send, finish
    task automatic run_image(input t_img_kind kind, input int unsigned n);
        t_entry      plan[$];
        t_entry      e;
        int unsigned pos;
        int unsigned c;
        int unsigned k;
        int unsigned pick;
        pos = 0;
        while (pos < n) begin
            c = $urandom_range(1, (n - pos > 8) ? 8 : n - pos);
            e.cnt = c[15:0];
            e.off = pos;
            plan = {plan, e};
            pos += c;
        end
        case (kind)
            IMG_GAP: begin
                if (plan.size() > 0) plan.delete($urandom_range(0, plan.size() - 1));
            end
            IMG_DUP: begin
                if (plan.size() > 0) begin
                    e = plan[$urandom_range(0, plan.size() - 1)];
                    repeat ($urandom_range(1, 3)) plan = {plan, e};
                end
            end
            IMG_WRAP: begin
                // end = 2^32 - k + cnt with cnt >= k
                k     = $urandom_range(1, 8);
                e.cnt = 16'(k + $urandom_range(0, 8));
                e.off = 32'd0 - k;
                plan = {plan, e};
            end
            IMG_NOISE: begin
                plan.delete();
                repeat ($urandom_range(1, 8)) begin
                    e.cnt = 16'($urandom_range(0, 8));
                    e.off = $urandom_range(0, n + 4);
                    plan = {plan, e};
                end
            end
            IMG_WIDE: begin
                k     = $urandom_range(0, 3);
                e.cnt = 16'(k + $urandom_range(1, 4));
                e.off = STORE_DEPTH - k;
                plan = {plan, e};
            end
            default: ;
        endcase
        // order of entries does not matter to the cover, shuffle most images
        if ($urandom_range(0, 3) != 0) begin
            for (int i = plan.size() - 1; i > 0; i--) begin
                pick       = $urandom_range(0, i);
                e          = plan[i];
                plan[i]    = plan[pick];
                plan[pick] = e;
            end
        end
        foreach (plan[i]) begin
            // empty voxels between real ones, any offset
            if ($urandom_range(0, 3) == 0) send_beat(fici_pkg::ACT_ENTRY, 16'd0, $urandom);
            send_beat(fici_pkg::ACT_ENTRY, plan[i].cnt, plan[i].off);
        end
        // finish ignores count and offset
        send_beat(fici_pkg::ACT_FINISH, 16'($urandom), $urandom);
    endtask

    initial begin
        logic [31:0] hdr;
        logic        given;
        int unsigned n;
        int unsigned roll;
        t_img_kind   kind;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass after reset
        do @(posedge clk); while (s_tready !== 1'b1);

        // empty image against a declared total of zero
        set_header(32'd0, 1'b1);
        send_beat(fici_pkg::ACT_FINISH, 16'hFFFF, 32'hFFFF_FFFF);
        drain();
        set_header(32'hFFFF_FFFF, 1'b1);
        // whole store covered once by a maximal entry and a single fixel
        send_beat(fici_pkg::ACT_ENTRY, 16'hFFFF, 32'd0);
        send_beat(fici_pkg::ACT_ENTRY, 16'd1, 32'd65535);
        send_beat(fici_pkg::ACT_FINISH, 16'd0, 32'd0);
        // end exactly at the 32-bit limit: no wrap, but past the store
        send_beat(fici_pkg::ACT_ENTRY, 16'd1, 32'hFFFF_FFFE);
        send_beat(fici_pkg::ACT_ENTRY, 16'd0, 32'hFFFF_FFFF);
        send_beat(fici_pkg::ACT_FINISH, 16'd0, 32'd0);
        drain();
        set_header(32'd5, 1'b0);
        // wrap together with a capacity entry: wrap takes priority
        send_beat(fici_pkg::ACT_ENTRY, 16'd1, 32'hFFFF_FFFF);
        send_beat(fici_pkg::ACT_ENTRY, 16'd2, 32'd0);
        send_beat(fici_pkg::ACT_ENTRY, 16'd3, 32'd2);
        send_beat(fici_pkg::ACT_ENTRY, 16'd1, 32'h8000_0000);
        send_beat(fici_pkg::ACT_FINISH, 16'd0, 32'd0);
        // four copies of one tile: counter saturates at three
        repeat (4) send_beat(fici_pkg::ACT_ENTRY, 16'd2, 32'd0);
        send_beat(fici_pkg::ACT_ENTRY, 16'd1, 32'd2);
        send_beat(fici_pkg::ACT_FINISH, 16'd0, 32'd0);
        // hole at index two
        send_beat(fici_pkg::ACT_ENTRY, 16'd2, 32'd0);
        send_beat(fici_pkg::ACT_ENTRY, 16'd2, 32'd3);
        send_beat(fici_pkg::ACT_FINISH, 16'd0, 32'd0);
        // overlap at index two
        send_beat(fici_pkg::ACT_ENTRY, 16'd3, 32'd0);
        send_beat(fici_pkg::ACT_ENTRY, 16'd2, 32'd2);
        send_beat(fici_pkg::ACT_FINISH, 16'd0, 32'd0);
        drain();

        // random phases, each with its own header setting
        while (beats_sent < BEAT_TARGET) begin
            calm = (beats_sent > BEAT_TARGET - 90) || ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 4);
            case (roll)
                0:       hdr = 32'd0;
                1:       hdr = 32'hFFFF_FFFF;
                4:       hdr = $urandom;
                default: hdr = $urandom_range(0, 48);
            endcase
            given = 1'($urandom_range(0, 1));
            set_header(hdr, given);
            repeat ($urandom_range(1, 4)) begin
                roll = $urandom_range(0, 99);
                if (roll < 50)      kind = IMG_TILED;
                else if (roll < 62) kind = IMG_GAP;
                else if (roll < 74) kind = IMG_DUP;
                else if (roll < 84) kind = IMG_WRAP;
                else if (roll < 96) kind = IMG_NOISE;
                else if (wide_images < 2) kind = IMG_WIDE;
                else                kind = IMG_TILED;
                // wide images scan the whole store, keep them rare
                if (kind == IMG_WIDE) wide_images++;
                // often aim the image at the declared total
                n = (hdr <= 48 && $urandom_range(0, 1) == 1) ? hdr : $urandom_range(0, 48);
                run_image(kind, n);
            end
            drain();
        end

        if (cover_tracker.errors == 0 && cover_tracker.reports_due.size() == 0) begin
            $display("fixel_index_cover_check_core regression: pass");
        end else begin
            $display("fixel_index_cover_check_core regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fici_pkg.sv
rtl/fici_cover_ram.sv
rtl/fici_step_unit.sv
rtl/fixel_index_cover_check_core.sv
test/tb.sv
